// ----- design/pfa_pkg.sv -----
// shared widths, register codes, reset values and config type of the point force affector
`timescale 1ns / 1ps
package pfa_pkg;
	localparam int DATA_W  = 32;
	localparam int AGE_W   = 16;
	localparam int LIM_W   = 31;
	localparam int ADDR_W  = 5;
	localparam int SUM_W   = 64;
	localparam int ROOT_W  = 32;
	localparam int QUO_W   = 32;

	localparam logic [DATA_W-1:0] CENTER_RST      = 32'd0;
	localparam logic [DATA_W-1:0] STRENGTH_RST    = 32'd65536;
	localparam logic [LIM_W-1:0]  CUTOFF_RST      = 31'd65536;
	localparam logic [AGE_W-1:0]  AGE_LIMIT_RST   = 16'd350;
	localparam logic [LIM_W-1:0]  FORCE_LIMIT_RST = 31'd19660800;

	typedef enum logic [2:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_CENTER_Z,
		REG_STRENGTH,
		REG_CUTOFF,
		REG_AGE_LIMIT,
		REG_FORCE_LIMIT
	} reg_idx_t;

	typedef struct packed {
		logic [DATA_W-1:0] center_x;
		logic [DATA_W-1:0] center_y;
		logic [DATA_W-1:0] center_z;
		logic [DATA_W-1:0] strength;
		logic [LIM_W-1:0]  cutoff_radius;
		logic [AGE_W-1:0]  age_limit;
		logic [LIM_W-1:0]  force_limit;
	} cfg_t;
endpackage

// ----- design/pfa_chan_if.sv -----
// particle and force channel interfaces
`timescale 1ns / 1ps
interface pfa_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [15:0] age;
	logic signed [31:0] force_in_x;
	logic signed [31:0] force_in_y;
	logic signed [31:0] force_in_z;
	modport source (output valid, pos_x, pos_y, pos_z, age, force_in_x, force_in_y, force_in_z,
		input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, age, force_in_x, force_in_y, force_in_z,
		output ready);
endinterface

interface pfa_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] force_out_x;
	logic signed [31:0] force_out_y;
	logic signed [31:0] force_out_z;
	logic affected;
	modport source (output valid, force_out_x, force_out_y, force_out_z, affected, input ready);
	modport sink (input valid, force_out_x, force_out_y, force_out_z, affected, output ready);
endinterface

// ----- design/pfa_cfg.sv -----
// apb register file of the point force affector
`timescale 1ns / 1ps
module pfa_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [pfa_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output pfa_pkg::cfg_t             cfg
);
	pfa_pkg::cfg_t cfg_q;
	pfa_pkg::reg_idx_t idx;

	assign idx = pfa_pkg::reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x      <= pfa_pkg::CENTER_RST;
			cfg_q.center_y      <= pfa_pkg::CENTER_RST;
			cfg_q.center_z      <= pfa_pkg::CENTER_RST;
			cfg_q.strength      <= pfa_pkg::STRENGTH_RST;
			cfg_q.cutoff_radius <= pfa_pkg::CUTOFF_RST;
			cfg_q.age_limit     <= pfa_pkg::AGE_LIMIT_RST;
			cfg_q.force_limit   <= pfa_pkg::FORCE_LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				pfa_pkg::REG_CENTER_X:    cfg_q.center_x      <= pwdata;
				pfa_pkg::REG_CENTER_Y:    cfg_q.center_y      <= pwdata;
				pfa_pkg::REG_CENTER_Z:    cfg_q.center_z      <= pwdata;
				pfa_pkg::REG_STRENGTH:    cfg_q.strength      <= pwdata;
				pfa_pkg::REG_CUTOFF:      cfg_q.cutoff_radius <= pwdata[30:0];
				pfa_pkg::REG_AGE_LIMIT:   cfg_q.age_limit     <= pwdata[15:0];
				pfa_pkg::REG_FORCE_LIMIT: cfg_q.force_limit   <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pfa_pkg::REG_CENTER_X:    prdata = cfg_q.center_x;
			pfa_pkg::REG_CENTER_Y:    prdata = cfg_q.center_y;
			pfa_pkg::REG_CENTER_Z:    prdata = cfg_q.center_z;
			pfa_pkg::REG_STRENGTH:    prdata = cfg_q.strength;
			pfa_pkg::REG_CUTOFF:      prdata = {1'b0, cfg_q.cutoff_radius};
			pfa_pkg::REG_AGE_LIMIT:   prdata = {16'd0, cfg_q.age_limit};
			pfa_pkg::REG_FORCE_LIMIT: prdata = {1'b0, cfg_q.force_limit};
			default:                  prdata = 32'd0;
		endcase
	end
endmodule

// ----- design/pfa_isqrt.sv -----
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module pfa_isqrt #(
	parameter int RW = pfa_pkg::ROOT_W,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [2*RW-1:0] rad,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [RW-1:0] root,
	output logic [SW-1:0] side_out
);
	logic [RW+1:0]   rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [2*RW-1:0] rad_s  [RW];
	logic [SW-1:0]   side_s [RW];
	logic            vld_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [RW+1:0]   r_in;
		logic [RW-1:0]   t_in;
		logic [2*RW-1:0] x_in;
		logic [SW-1:0]   sd_in;
		logic            v_in;
		logic [RW+1:0]   r2;
		logic [RW+1:0]   trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign r_in  = '0;
			assign t_in  = '0;
			assign x_in  = rad;
			assign sd_in = side_in;
			assign v_in  = in_valid;
		end else begin : g_next
			assign r_in  = rem_s[k-1];
			assign t_in  = root_s[k-1];
			assign x_in  = rad_s[k-1];
			assign sd_in = side_s[k-1];
			assign v_in  = vld_s[k-1];
		end

		assign r2    = {r_in[RW-1:0], x_in[2*RW-1 -: 2]};
		assign trial = {t_in, 2'b01};
		assign ge    = r2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? r2 - trial : r2;
				root_s[k] <= {t_in[RW-2:0], ge};
				rad_s[k]  <= {x_in[2*RW-3:0], 2'b00};
				side_s[k] <= sd_in;
			end
		end
	end

	assign out_valid = vld_s[RW-1];
	assign root      = root_s[RW-1];
	assign side_out  = side_s[RW-1];
endmodule

// ----- design/pfa_udiv.sv -----
// pipelined restoring divider, one quotient bit per stage, quotient known to fit qw bits
`timescale 1ns / 1ps
module pfa_udiv #(
	parameter int DW = pfa_pkg::DATA_W,
	parameter int QW = pfa_pkg::QUO_W,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] rem0,
	input  logic [QW-1:0] low,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);
	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] sh_s   [QW];
	logic [DW-1:0] den_s  [QW];
	logic [SW-1:0] side_s [QW];
	logic          vld_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [QW-1:0] sh_in;
		logic [SW-1:0] sd_in;
		logic          v_in;
		logic [DW:0]   r2;
		logic [DW:0]   diff;

		if (k == 0) begin : g_first
			assign r_in  = rem0;
			assign d_in  = den;
			assign sh_in = low;
			assign sd_in = side_in;
			assign v_in  = in_valid;
		end else begin : g_next
			assign r_in  = rem_s[k-1];
			assign d_in  = den_s[k-1];
			assign sh_in = sh_s[k-1];
			assign sd_in = side_s[k-1];
			assign v_in  = vld_s[k-1];
		end

		assign r2   = {r_in, sh_in[QW-1]};
		assign diff = r2 - {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= diff[DW] ? r2[DW-1:0] : diff[DW-1:0];
				sh_s[k]   <= {sh_in[QW-2:0], ~diff[DW]};
				den_s[k]  <= d_in;
				side_s[k] <= sd_in;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quo       = sh_s[QW-1];
	assign side_out  = side_s[QW-1];
endmodule

// ----- design/point_force_affector_top.sv -----
// Point force affector: one particle word in and one force word out per clock cycle unless
// the output stalls, through five setup stages, a 32-stage square root running beside a
// 32-stage strength divider, two scaling stages, three 32-stage direction dividers and the
// output register. The rate is set by the bit-per-stage root and divider pipelines. The whole
// pipeline holds while a finished word waits at the output. Config is written through apb.
`timescale 1ns / 1ps
module point_force_affector_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pfa_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	pfa_in_if.sink                     in_ch,
	pfa_out_if.source                  out_ch
);
	typedef struct packed {
		logic             pass;
		logic [2:0]       pos;
		logic [2:0][30:0] mag;
		logic [2:0][31:0] frc;
	} sq_side_t;

	typedef struct packed {
		logic             pass;
		logic             pos;
		logic [2:0][31:0] frc;
	} lane_side_t;

	pfa_pkg::cfg_t cfg;
	logic en, neg;
	logic [31:0] sabs, lim;

	pfa_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	assign neg  = cfg.strength[31];
	assign sabs = neg ? (~cfg.strength + 32'd1) : cfg.strength;
	assign lim  = neg ? 32'h8000_0000 : {1'b0, cfg.force_limit};

	logic vld_s8;
	assign en = !vld_s8 || out_ch.ready;
	assign in_ch.ready = en;

	// offsets and age test
	logic             vld_s1, old_s1;
	logic [2:0][32:0] d_s1;
	logic [2:0][31:0] f_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= {cfg.center_x[31], cfg.center_x} - {in_ch.pos_x[31], in_ch.pos_x};
			d_s1[1] <= {cfg.center_y[31], cfg.center_y} - {in_ch.pos_y[31], in_ch.pos_y};
			d_s1[2] <= {cfg.center_z[31], cfg.center_z} - {in_ch.pos_z[31], in_ch.pos_z};
			f_s1[0] <= in_ch.force_in_x;
			f_s1[1] <= in_ch.force_in_y;
			f_s1[2] <= in_ch.force_in_z;
			old_s1  <= in_ch.age > cfg.age_limit;
		end
	end

	// magnitudes, cutoff box test, signs
	logic             vld_s2, pass_s2;
	logic [2:0]       pos_s2;
	logic [2:0][30:0] a_s2;
	logic [2:0][31:0] f_s2;
	logic [2:0][32:0] a1;
	logic [2:0]       far1, nz1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a1[i]   = d_s1[i][32] ? (~d_s1[i] + 33'd1) : d_s1[i];
			far1[i] = a1[i] > {2'b00, cfg.cutoff_radius};
			nz1[i]  = d_s1[i] != 33'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pass_s2 <= old_s1 || (|far1) || !(|nz1);
			for (int i = 0; i < 3; i++) begin
				a_s2[i]   <= a1[i][30:0];
				pos_s2[i] <= neg ? (!d_s1[i][32] && nz1[i]) : d_s1[i][32];
			end
			f_s2 <= f_s1;
		end
	end

	// squares
	logic             vld_s3, pass_s3;
	logic [2:0]       pos_s3;
	logic [2:0][30:0] a_s3;
	logic [2:0][31:0] f_s3;
	logic [2:0][61:0] sq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= {31'd0, a_s2[i]} * {31'd0, a_s2[i]};
			end
			pass_s3 <= pass_s2;
			pos_s3  <= pos_s2;
			a_s3    <= a_s2;
			f_s3    <= f_s2;
		end
	end

	// squared distance
	logic                      vld_s4;
	sq_side_t                  side_s4;
	logic [pfa_pkg::SUM_W-1:0] s_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s4 <= {2'b00, sq_s3[0]} + {2'b00, sq_s3[1]} + {2'b00, sq_s3[2]};
			side_s4.pass <= pass_s3;
			side_s4.pos  <= pos_s3;
			side_s4.mag  <= a_s3;
			side_s4.frc  <= f_s3;
		end
	end

	// strength over distance squared overflows 32 bits
	logic                      vld_s5, big_s5;
	sq_side_t                  side_s5;
	logic [pfa_pkg::SUM_W-1:0] s_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			big_s5  <= {32'd0, sabs} >= s_s4;
			s_s5    <= s_s4;
			side_s5 <= side_s4;
		end
	end

	logic                       sq_vld, qd_vld, qd_big;
	logic [pfa_pkg::ROOT_W-1:0] root_d;
	logic [pfa_pkg::QUO_W-1:0]  qv;
	sq_side_t                   sq_side;

	pfa_isqrt #(.RW(pfa_pkg::ROOT_W), .SW($bits(sq_side_t))) u_sqrt (
		.clk, .arst_n, .en,
		.in_valid (vld_s5),
		.rad      (s_s5),
		.side_in  (side_s5),
		.out_valid(sq_vld),
		.root     (root_d),
		.side_out (sq_side)
	);

	pfa_udiv #(.DW(pfa_pkg::SUM_W), .QW(pfa_pkg::QUO_W), .SW(1)) u_qdiv (
		.clk, .arst_n, .en,
		.in_valid (vld_s5),
		.rem0     ({32'd0, sabs}),
		.low      ('0),
		.den      (s_s5),
		.side_in  (big_s5),
		.out_valid(qd_vld),
		.quo      (qv),
		.side_out (qd_big)
	);

	// clamped magnitude and radius test
	logic             vld_s6, pass_s6;
	logic [31:0]      m_s6, dist_s6;
	logic [2:0]       pos_s6;
	logic [2:0][30:0] a_s6;
	logic [2:0][31:0] f_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (en) vld_s6 <= sq_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s6    <= (qd_big || qv > lim) ? lim : qv;
			pass_s6 <= sq_side.pass || root_d > {1'b0, cfg.cutoff_radius};
			dist_s6 <= root_d;
			pos_s6  <= sq_side.pos;
			a_s6    <= sq_side.mag;
			f_s6    <= sq_side.frc;
		end
	end

	// magnitude times component
	logic             vld_s7;
	logic [31:0]      dist_s7;
	logic [2:0][62:0] p_s7;
	lane_side_t       side_s7;
	logic [2:0]       pos_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (en) vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s7[i] <= {31'd0, m_s6} * {32'd0, a_s6[i]};
			end
			dist_s7      <= dist_s6;
			pos_s7       <= pos_s6;
			side_s7.pass <= pass_s6;
			side_s7.pos  <= pos_s6[0];
			side_s7.frc  <= f_s6;
		end
	end

	logic [2:0]       ln_vld;
	logic [2:0][31:0] c;
	lane_side_t       ln_side;
	logic [2:0]       ln_pos;

	pfa_udiv #(.DW(pfa_pkg::DATA_W), .QW(pfa_pkg::QUO_W), .SW($bits(lane_side_t))) u_ldiv0 (
		.clk, .arst_n, .en,
		.in_valid (vld_s7),
		.rem0     ({1'b0, p_s7[0][62:32]}),
		.low      (p_s7[0][31:0]),
		.den      (dist_s7),
		.side_in  (side_s7),
		.out_valid(ln_vld[0]),
		.quo      (c[0]),
		.side_out (ln_side)
	);

	for (genvar i = 1; i < 3; i++) begin : g_lane
		pfa_udiv #(.DW(pfa_pkg::DATA_W), .QW(pfa_pkg::QUO_W), .SW(1)) u_ldiv (
			.clk, .arst_n, .en,
			.in_valid (vld_s7),
			.rem0     ({1'b0, p_s7[i][62:32]}),
			.low      (p_s7[i][31:0]),
			.den      (dist_s7),
			.side_in  (pos_s7[i]),
			.out_valid(ln_vld[i]),
			.quo      (c[i]),
			.side_out (ln_pos[i])
		);
	end

	assign ln_pos[0] = ln_side.pos;

	// add and saturate
	logic [2:0][31:0] fo_s8;
	logic             aff_s8;
	logic [2:0][33:0] sum;
	logic [2:0][31:0] sat;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = ln_pos[i] ? {{2{ln_side.frc[i][31]}}, ln_side.frc[i]} + {2'b00, c[i]}
				: {{2{ln_side.frc[i][31]}}, ln_side.frc[i]} - {2'b00, c[i]};
			if (sum[i][33:31] == 3'b000 || sum[i][33:31] == 3'b111) begin
				sat[i] = sum[i][31:0];
			end else begin
				sat[i] = sum[i][33] ? 32'h8000_0000 : 32'h7fff_ffff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else if (en) vld_s8 <= ln_vld[0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fo_s8  <= ln_side.pass ? ln_side.frc : sat;
			aff_s8 <= !ln_side.pass;
		end
	end

	assign out_ch.valid       = vld_s8;
	assign out_ch.force_out_x = fo_s8[0];
	assign out_ch.force_out_y = fo_s8[1];
	assign out_ch.force_out_z = fo_s8[2];
	assign out_ch.affected    = aff_s8;

	a_units_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld == qd_vld) else $error("root and strength divider out of step");
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		ln_vld[0] == ln_vld[1] && ln_vld[0] == ln_vld[2])
		else $error("direction divider lanes out of step");
	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |-> !in_ch.ready)
		else $error("input taken while output word stalled");
	a_mag_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 && !pass_s6 |-> m_s6 <= lim) else $error("force magnitude above limit");
endmodule
